[rtl/core/wprm_pkg.sv]
// ============================================================================
// wprm_pkg - shared types and constants of the windowed peak RMS meter
// Frame and result payloads, the window job record handed from the
// accumulator to the arithmetic back end, and the back end state type.
// ============================================================================
package wprm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = 63;
    localparam int LEN_BITS    = 16;
    localparam int OUT_BITS    = 24;
    localparam int ROOT_BITS   = 32;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int CNT_BITS    = 6;

    localparam logic [LEN_BITS-1:0] WINDOW_LENGTH_RESET = 16'd960;
    localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(SUM_BITS - 1);
    localparam logic [CNT_BITS-1:0] SQRT_LAST = CNT_BITS'(ROOT_BITS - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          last_frame;
    } t_frame;

    typedef struct packed {
        logic [OUT_BITS-1:0] peak_rms;
        logic [OUT_BITS-1:0] peak_level;
    } t_result;

    // One closed window: its sum, the divisor in force, and on the last
    // frame the peak level of the whole extent.
    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [LEN_BITS-1:0]    divisor;
        logic                   last;
        logic [SAMPLE_BITS-1:0] level;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_back_state;

    function automatic logic [SAMPLE_BITS-1:0] magnitude(
        input logic signed [SAMPLE_BITS-1:0] x
    );
        logic [SAMPLE_BITS-1:0] u;
        u = x;
        return u[SAMPLE_BITS-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

[rtl/core/wprm_front.sv]
// ============================================================================
// wprm_front - frame level and window accumulator
// Takes one frame a cycle unless a full queue holds it, squares its level in
// a registered multiplier and sums windows; each closed window is a queue job.
// ============================================================================
module wprm_front import wprm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEN_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_frame              i_frame,
    input  logic                i_q_full,
    output logic                o_push,
    output t_job                o_job
);

    logic [LEN_BITS-1:0]    r_window_length;
    logic                   r_v1;
    logic [SAMPLE_BITS-1:0] r_lvl1;
    logic                   r_last1;
    logic                   r_v2;
    logic [SQ_BITS-1:0]     r_sq2;
    logic [SAMPLE_BITS-1:0] r_lvl2;
    logic                   r_last2;
    logic [SUM_BITS-1:0]    r_sum;
    logic [LEN_BITS-1:0]    r_fill;
    logic [SAMPLE_BITS-1:0] r_peak;

    logic [SAMPLE_BITS-1:0] w_mag_l;
    logic [SAMPLE_BITS-1:0] w_mag_r;
    logic [SUM_BITS-1:0]    n_sum;
    logic [LEN_BITS-1:0]    n_fill;
    logic [SAMPLE_BITS-1:0] n_peak;
    logic [LEN_BITS-1:0]    w_eff;
    logic                   w_close;
    logic                   w_adv;

    assign w_mag_l = magnitude(i_frame.left_sample);
    assign w_mag_r = magnitude(i_frame.right_sample);

    assign n_sum   = r_sum + {{(SUM_BITS-SQ_BITS){1'b0}}, r_sq2};
    assign n_fill  = r_fill + 1'b1;
    assign n_peak  = (r_lvl2 > r_peak) ? r_lvl2 : r_peak;
    assign w_eff   = (r_window_length == '0) ? LEN_BITS'(1) : r_window_length;
    assign w_close = (n_fill >= w_eff) || r_last2;

    // Hold the whole pipe while a closing window finds the queue full.
    assign w_adv      = !(r_v2 && w_close && i_q_full);
    assign o_in_ready = w_adv;
    assign o_push     = r_v2 && w_close && !i_q_full;

    assign o_job.sum     = n_sum;
    assign o_job.divisor = w_eff;
    assign o_job.last    = r_last2;
    assign o_job.level   = n_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_window_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_sum  <= '0;
            r_fill <= '0;
            r_peak <= '0;
        end else if (w_adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_sum  <= w_close ? '0 : n_sum;
                r_fill <= w_close ? '0 : n_fill;
                r_peak <= r_last2 ? '0 : n_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lvl1  <= (w_mag_l > w_mag_r) ? w_mag_l : w_mag_r;
            r_last1 <= i_frame.last_frame;
            r_sq2   <= r_lvl1 * r_lvl1;
            r_lvl2  <= r_lvl1;
            r_last2 <= r_last1;
        end
    end

endmodule

[rtl/core/wprm_queue.sv]
// ============================================================================
// wprm_queue - window job queue
// Small FIFO between the accumulator and the divide and root back end.
// ============================================================================
module wprm_queue import wprm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/wprm_back.sv]
// ============================================================================
// wprm_back - window divide, peak hold and square root
// Divides each window sum one quotient bit a cycle, keeps the largest mean
// square, and on the last window extracts its root digit by digit.
// ============================================================================
module wprm_back import wprm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    t_back_state            r_state;
    t_back_state            n_state;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [SUM_BITS-1:0]    r_dvd;
    logic [LEN_BITS-1:0]    r_div;
    logic [LEN_BITS-1:0]    r_rem;
    logic                   r_last;
    logic [SAMPLE_BITS-1:0] r_level;
    logic [SUM_BITS-1:0]    r_peak_ms;
    logic [RAD_BITS-1:0]    r_rad;
    logic [ROOT_BITS+1:0]   r_srem;
    logic [ROOT_BITS-1:0]   r_root;
    t_result                r_result;

    logic [LEN_BITS:0]      w_rsh;
    logic                   w_qbit;
    logic [LEN_BITS:0]      w_rdiff;
    logic [SUM_BITS-1:0]    w_quot;
    logic [SUM_BITS-1:0]    w_new_peak;
    logic [ROOT_BITS+3:0]   w_acc;
    logic [ROOT_BITS+3:0]   w_try;
    logic                   w_rbit;
    logic [ROOT_BITS+3:0]   w_sdiff;

    // Restoring divide step.
    assign w_rsh      = {r_rem, r_dvd[SUM_BITS-1]};
    assign w_qbit     = (w_rsh >= {1'b0, r_div});
    assign w_rdiff    = w_rsh - {1'b0, r_div};
    assign w_quot     = {r_dvd[SUM_BITS-2:0], w_qbit};
    assign w_new_peak = (w_quot > r_peak_ms) ? w_quot : r_peak_ms;

    // Digit-by-digit root step.
    assign w_acc   = {r_srem, r_rad[RAD_BITS-1 -: 2]};
    assign w_try   = {2'b00, r_root, 2'b01};
    assign w_rbit  = (w_acc >= w_try);
    assign w_sdiff = w_acc - w_try;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = r_last ? ST_SQRT : ST_IDLE;
                end
            end
            ST_SQRT: begin
                if (r_cnt == SQRT_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop       = i_q_valid;
            ST_OUT:  o_out_valid = 1'b1;
            default: begin
                o_pop       = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_peak_ms <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV && r_cnt == DIV_LAST) begin
                r_peak_ms <= w_new_peak;
            end else if (r_state == ST_SQRT && r_cnt == SQRT_LAST) begin
                r_peak_ms <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cnt   <= '0;
                r_dvd   <= i_job.sum;
                r_div   <= i_job.divisor;
                r_rem   <= '0;
                r_last  <= i_job.last;
                r_level <= i_job.level;
            end
            ST_DIV: begin
                r_cnt <= (r_cnt == DIV_LAST) ? '0 : r_cnt + 1'b1;
                r_dvd <= w_quot;
                r_rem <= w_qbit ? w_rdiff[LEN_BITS-1:0] : w_rsh[LEN_BITS-1:0];
                if (r_cnt == DIV_LAST) begin
                    // Load the root unit with the updated peak.
                    r_rad  <= {{(RAD_BITS-SUM_BITS){1'b0}}, w_new_peak};
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            ST_SQRT: begin
                r_cnt  <= r_cnt + 1'b1;
                r_rad  <= {r_rad[RAD_BITS-3:0], 2'b00};
                r_srem <= w_rbit ? w_sdiff[ROOT_BITS+1:0] : w_acc[ROOT_BITS+1:0];
                r_root <= {r_root[ROOT_BITS-2:0], w_rbit};
                if (r_cnt == SQRT_LAST) begin
                    r_result.peak_rms   <= OUT_BITS'({r_root[ROOT_BITS-2:0], w_rbit});
                    r_result.peak_level <= OUT_BITS'(r_level);
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

[rtl/core/windowed_peak_rms_meter.sv]
// ============================================================================
// windowed_peak_rms_meter - block RMS level meter with peak hold
// Top level: frame accumulator, window job queue and divide/root back end.
// ============================================================================
// One stereo frame is accepted per cycle while the input is not stalled; its
// level (larger channel magnitude) is squared and summed into windows of
// window_length frames, a length of zero acting as one. Every closed window
// becomes a job in a QUEUE_DEPTH entry queue; the back end divides each job
// one quotient bit a cycle and takes no new job meanwhile, and the input
// stalls when a window closes while the queue is full. On the frame flagged
// last, the open window is closed, the back end takes the square root of the
// largest window mean square, and one result (peak RMS, peak level) is
// offered; the window sums and peaks then start over. The result waits for
// any jobs still queued ahead of it.
module windowed_peak_rms_meter import wprm_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEN_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_frame              i_frame,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_result             o_result
);

    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_valid;
    t_job w_job_in;
    t_job w_job_out;

    wprm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_frame    (i_frame),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    wprm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_job_out)
    );

    wprm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) !(w_push && w_q_full)
    ) else $error("window job pushed into a full queue");

    a_no_pop_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_pop |-> w_q_valid
    ) else $error("window job popped from an empty queue");

    a_stall_only_on_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) !o_in_ready |-> w_q_full
    ) else $error("input stalled while the queue had room");

    a_result_only_after_pop: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_pop |=> !o_out_valid
    ) else $error("result offered right after a job was taken");

endmodule

[tb/sv/tb_windowed_peak_rms_meter.sv]
// ----------------------------------------------------------------------------
// tb_windowed_peak_rms_meter - self-checking bench for the peak RMS meter
// Streams stereo frames through the valid/ready input with random gaps, pulls
// results with random stalls, and checks each peak RMS / peak level pair
// against a cycle-free model of the windowed mean-square accumulation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_windowed_peak_rms_meter;
    import wprm_pkg::*;

    localparam int          MAX_S         = 8388607;
    localparam int          MIN_S         = -8388608;
    localparam int unsigned SETTLE_CYCLES = 600;
    localparam int unsigned MAX_CYCLES    = 1000000;

    typedef enum {
        FEED_FRAME,
        FEED_CFG,
        FEED_DRAIN
    } t_feed_op;

    typedef struct {
        t_feed_op            op;
        t_frame              frame;
        logic [LEN_BITS-1:0] len;
    } t_feed;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [LEN_BITS-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_frame              i_frame    = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_result             o_result;

    t_feed       feed_q[$];
    t_result     peak_results_q[$];

    // meter model state
    logic [LEN_BITS-1:0] win_len    = WINDOW_LENGTH_RESET;
    logic [62:0]         acc_sum    = '0;
    logic [15:0]         acc_fill   = '0;
    logic [63:0]         held_ms    = '0;
    logic [23:0]         held_level = '0;

    bit          in_fire;
    bit          out_fire;
    bit          send_calm;
    bit          recv_calm;
    int unsigned send_gap;
    int unsigned drain_hold;
    int unsigned idle_run;
    int unsigned cycle_count;
    int unsigned mismatch_count;

    windowed_peak_rms_meter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_frame     (i_frame),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [23:0] level_of(logic [23:0] raw);
        return raw[23] ? 24'(25'h1000000 - 25'(raw)) : raw;
    endfunction

    function automatic logic [31:0] root_floor(logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= v) r = t;
        end
        return r;
    endfunction

    task automatic close_window();
        logic [63:0] divisor;
        logic [63:0] ms;
        divisor = (win_len == 0) ? 64'd1 : 64'(win_len);
        ms = 64'(acc_sum) / divisor;
        if (ms > held_ms) held_ms = ms;
        acc_sum  = '0;
        acc_fill = '0;
    endtask

    task automatic account_frame(input t_frame f);
        logic [23:0] la;
        logic [23:0] lb;
        logic [23:0] lvl;
        t_result     res;
        la  = level_of(f.left_sample);
        lb  = level_of(f.right_sample);
        lvl = (la > lb) ? la : lb;
        if (lvl > held_level) held_level = lvl;
        acc_sum  = 63'(64'(acc_sum) + 64'(lvl) * 64'(lvl));
        acc_fill = acc_fill + 16'd1;
        if (acc_fill >= ((win_len == 0) ? 16'd1 : win_len)) close_window();
        if (f.last_frame) begin
            if (acc_fill != 0) close_window();
            res.peak_rms   = 24'(root_floor(held_ms));
            res.peak_level = held_level;
            peak_results_q.insert(peak_results_q.size(), res);
            acc_sum    = '0;
            acc_fill   = '0;
            held_ms    = '0;
            held_level = '0;
        end
    endtask

    function automatic int unsigned pick_wait(inout bit calm);
        if ($urandom_range(0, 49) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 7))
            0: return MIN_S;
            1: return MAX_S;
            2: return int'($urandom_range(0, 510)) - 255;
            default: return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        endcase
    endfunction

    function automatic int unsigned pick_extent();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(61, 600)
                                           : $urandom_range(1, 60);
    endfunction

    function automatic logic [LEN_BITS-1:0] phase_len(int p);
        case (p)
            0: return 16'd64;
            1: return 16'd960;
            2: return 16'd65535;
            3: return 16'($urandom_range(2, 12));
            4: return 16'd0;
            7: return 16'($urandom_range(401, 2000));
            9: return 16'd64;
            default: return 16'($urandom_range(65, 400));
        endcase
    endfunction

    task automatic add_frame(input int l, input int r, input bit last);
        t_feed it;
        it.op                 = FEED_FRAME;
        it.frame.left_sample  = l[23:0];
        it.frame.right_sample = r[23:0];
        it.frame.last_frame   = last;
        it.len                = '0;
        feed_q.insert(feed_q.size(), it);
    endtask

    task automatic add_cfg(input logic [LEN_BITS-1:0] len);
        t_feed it;
        it.op    = FEED_CFG;
        it.frame = '0;
        it.len   = len;
        feed_q.insert(feed_q.size(), it);
    endtask

    // Frame driver: one transaction at a time from feed_q, register writes
    // only once the meter has gone quiet.
    always @(negedge i_clk) begin
        logic                nxt_valid;
        t_frame              nxt_frame;
        logic                nxt_we;
        logic [LEN_BITS-1:0] nxt_data;
        t_feed               head;
        nxt_valid = i_in_valid;
        nxt_frame = i_frame;
        nxt_we    = 1'b0;
        nxt_data  = i_cfg_data;
        if (i_rst_n) begin
            if (in_fire) begin
                nxt_valid = 1'b0;
                send_gap  = pick_wait(send_calm);
            end
            if (!nxt_valid && feed_q.size() != 0) begin
                head = feed_q[0];
                if (head.op == FEED_FRAME) begin
                    if (send_gap == 0) begin
                        nxt_valid = 1'b1;
                        nxt_frame = head.frame;
                        void'(feed_q.pop_front());
                    end else begin
                        send_gap--;
                    end
                end else if (peak_results_q.size() != 0) begin
                    idle_run = 0;
                end else if (head.op == FEED_CFG && idle_run < SETTLE_CYCLES) begin
                    // let queued window jobs run out before touching the length
                    idle_run++;
                end else begin
                    if (head.op == FEED_CFG) begin
                        nxt_we   = 1'b1;
                        nxt_data = head.len;
                    end
                    idle_run = 0;
                    void'(feed_q.pop_front());
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_frame    <= nxt_frame;
        i_cfg_we   <= nxt_we;
        i_cfg_data <= nxt_data;
    end

    // Result receiver: random stall before each transaction.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) drain_hold = pick_wait(recv_calm);
            if (drain_hold != 0) begin
                drain_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("%0t timeout with %0d results pending", $time, peak_results_q.size());
            $display("tb: failure");
            $finish;
        end else begin
            in_fire  = i_rst_n && i_in_valid && o_in_ready;
            out_fire = i_rst_n && o_out_valid && i_out_ready;
            if (!i_rst_n) begin
                win_len    = WINDOW_LENGTH_RESET;
                acc_sum    = '0;
                acc_fill   = '0;
                held_ms    = '0;
                held_level = '0;
            end else begin
                if (i_cfg_we) win_len = i_cfg_data;
                if (in_fire) account_frame(i_frame);
                if (out_fire) begin
                    if (peak_results_q.size() == 0) begin
                        $display("%0t unexpected result: expected none actual %0d %0d",
                                 $time, o_result.peak_rms, o_result.peak_level);
                        mismatch_count++;
                    end else begin
                        want = peak_results_q.pop_front();
                        if (o_result.peak_rms !== want.peak_rms) begin
                            $display("%0t peak_rms mismatch: expected %0d actual %0d",
                                     $time, want.peak_rms, o_result.peak_rms);
                            mismatch_count++;
                        end
                        if (o_result.peak_level !== want.peak_level) begin
                            $display("%0t peak_level mismatch: expected %0d actual %0d",
                                     $time, want.peak_level, o_result.peak_level);
                            mismatch_count++;
                        end
                    end
                end
            end
        end
    end

    initial begin
        int unsigned ext;
        int unsigned budget;
        bit          closing;
        bit          drained;
        t_feed       hold_item;
        drained = 1'b0;

        // reset length in force: partial windows divided by 960
        add_frame(0, 0, 1'b0);
        add_frame(MAX_S, MIN_S, 1'b0);
        add_frame(MIN_S, MAX_S, 1'b0);
        add_frame(-1, 1, 1'b0);
        add_frame(5592405, -2796203, 1'b1);
        add_frame(MIN_S, MIN_S, 1'b1);
        add_frame(0, 0, 1'b1);
        // zero length acts as one: full-scale window gives peak RMS of 2^23
        add_cfg(16'd0);
        add_frame(MIN_S, 0, 1'b0);
        add_frame(5, -3, 1'b1);
        add_cfg(16'd1);
        add_frame(100, -200, 1'b0);
        add_frame(-7, 7, 1'b1);
        // window that closes exactly on the last frame, then one left partial
        add_cfg(16'd3);
        add_frame(3000000, -12, 1'b0);
        add_frame(-4000000, 77, 1'b0);
        add_frame(65535, -65536, 1'b1);
        add_frame(1, 2, 1'b0);
        add_frame(-8000000, 8000000, 1'b0);
        add_frame(42, -42, 1'b0);
        add_frame(MAX_S, 0, 1'b1);
        // open a long window, then shrink the length below its fill
        add_cfg(16'd65535);
        for (int k = 0; k < 5; k++) add_frame(pick_sample(), pick_sample(), 1'b0);
        add_cfg(16'd2);
        add_frame(-2500000, 1234567, 1'b0);
        add_frame(333, -444, 1'b1);

        for (int p = 0; p < 10; p++) begin
            add_cfg(phase_len(p));
            budget = (p == 3 || p == 4) ? 60 : 190;
            ext    = pick_extent();
            for (int k = 0; k < budget; k++) begin
                ext--;
                // phase 5 stops inside an extent so the next write lands mid-window
                closing = (ext == 0) || (k == budget - 1 && p != 5);
                add_frame(pick_sample(), pick_sample(), closing);
                if (closing) begin
                    ext = pick_extent();
                    if (!drained || $urandom_range(0, 19) == 0) begin
                        hold_item.op    = FEED_DRAIN;
                        hold_item.frame = '0;
                        hold_item.len   = '0;
                        feed_q.insert(feed_q.size(), hold_item);
                        drained = 1'b1;
                    end
                end
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (peak_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
